// ===== hdl/pdt_pkg.sv =====
package pdt_pkg;

   // Longest supported row; the column counter is sized from it.
   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int IMG_W     = 13;
   localparam int SEED_W    = 16;
   localparam int PIX_W     = 8;
   // Common width for comparing the column against the row length.
   localparam int CMP_W     = (COL_W + 1 > IMG_W) ? COL_W + 1 : IMG_W;

   localparam logic [CMP_W-1:0]  MAX_WIDTH_C = CMP_W'(MAX_WIDTH);
   localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;
   localparam logic [PIX_W-1:0]  LEVEL_0     = 8'd0;
   localparam logic [PIX_W-1:0]  LEVEL_1     = 8'd85;
   localparam logic [PIX_W-1:0]  LEVEL_2     = 8'd170;
   localparam logic [PIX_W-1:0]  LEVEL_3     = 8'd255;

   typedef enum logic [2:0] {
      MODE_FIXED  = 3'd0,
      MODE_RANDOM = 3'd1,
      MODE_BAYER2 = 3'd2,
      MODE_BAYER4 = 3'd3,
      MODE_BAYER8 = 3'd4,
      MODE_LEVEL4 = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE      = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_WIDTH     = 2'd2,
      REG_SEED      = 2'd3
   } reg_type;

   typedef struct packed {
      mode_type           mode;
      logic [PIX_W-1:0]   fixed_threshold;
      logic [IMG_W-1:0]   image_width;
      logic [SEED_W-1:0]  random_seed;
   } cfg_type;

   // One pixel with its screen position and noise byte, held in the input stage.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [2:0]       row;
      logic [2:0]       col;
      logic [PIX_W-1:0] noise;
   } pos_type;

   // Base 2x2 index matrix [[1,2],[3,0]].
   function automatic logic [1:0] bayer_cell(input logic r, input logic c);
      logic [1:0] v;
      case ({r, c})
         2'b00:   v = 2'd1;
         2'b01:   v = 2'd2;
         2'b10:   v = 2'd3;
         default: v = 2'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/pixel_dither_thresholder.sv =====
// Channel   Direction  Transfer                       Payload
// req_      in         req_tvalid & req_tready        tdata[7:0] pixel_in, tuser frame_start
// rsp_      out        rsp_tvalid & rsp_tready        tdata[7:0] pixel_out
// csr_      in         psel & penable & pwrite        mode, fixed_threshold, image_width,
//                                                     random_seed at 0x0, 0x4, 0x8, 0xC
//
// One pixel per clock while the output is not stalled; a req transfer reaches rsp_tvalid through both stages.
// Stage one registers the pixel with its row, column and noise byte; stage two
// holds the halftoned result, both advancing whenever the output is free.
// Reset is synchronous: scan position clears, noise generator loads one,
// registers take their defaults. A stalled output holds both stages in place.
module pixel_dither_thresholder
   import pdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   pos_type pos;
   logic    pos_valid;
   logic    take;

   pdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .pixel_in    (req_tdata),
      .frame_start (req_tuser),
      .take        (take),
      .pos_valid   (pos_valid),
      .pos         (pos)
   );

   pdt_halftone u_halftone (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pos_valid  (pos_valid),
      .pos        (pos),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_out  (rsp_tdata)
   );

endmodule

// ===== hdl/pdt_csr.sv =====
module pdt_csr
   import pdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   reg_type sel;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign sel        = reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_MODE:      cfg_in.mode            = mode_type'(csr_pwdata[2:0]);
            REG_THRESHOLD: cfg_in.fixed_threshold = csr_pwdata[PIX_W-1:0];
            REG_WIDTH:     cfg_in.image_width     = csr_pwdata[IMG_W-1:0];
            REG_SEED:      cfg_in.random_seed     = csr_pwdata[SEED_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= MODE_BAYER4;
         cfg_ff.fixed_threshold <= 8'd127;
         cfg_ff.image_width     <= 13'd512;
         cfg_ff.random_seed     <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel)
         REG_MODE:      csr_prdata = {29'd0, cfg_ff.mode};
         REG_THRESHOLD: csr_prdata = {24'd0, cfg_ff.fixed_threshold};
         REG_WIDTH:     csr_prdata = {19'd0, cfg_ff.image_width};
         REG_SEED:      csr_prdata = {16'd0, cfg_ff.random_seed};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/pdt_scan.sv =====
module pdt_scan
   import pdt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] pixel_in,
   input  logic             frame_start,
   input  logic             take,
   output logic             pos_valid,
   output pos_type          pos
);

   logic [COL_W-1:0]  col_ff, col_in, col_cur;
   logic [2:0]        row_ff, row_in, row_cur;
   logic [SEED_W-1:0] lfsr_ff, lfsr_in, lfsr_cur;
   logic              valid_ff, valid_in;
   pos_type           pos_ff, pos_in;
   logic              accept;
   logic [CMP_W-1:0]  img_ext, eff_width, col_next;

   assign req_tready = ~valid_ff | take;
   assign accept     = req_tvalid & req_tready;

   // Frame start restarts the scan before this pixel is used.
   always_comb begin
      if (frame_start) begin
         col_cur  = '0;
         row_cur  = '0;
         lfsr_cur = (cfg.random_seed == '0) ? SEED_W'(1) : cfg.random_seed;
      end else begin
         col_cur  = col_ff;
         row_cur  = row_ff;
         lfsr_cur = lfsr_ff;
      end
   end

   always_comb begin
      img_ext = CMP_W'(cfg.image_width);
      if (img_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (img_ext > MAX_WIDTH_C) begin
         eff_width = MAX_WIDTH_C;
      end else begin
         eff_width = img_ext;
      end
      col_next = CMP_W'(col_cur) + CMP_W'(1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      lfsr_in  = lfsr_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in     = 1'b1;
         pos_in.pixel = pixel_in;
         pos_in.row   = row_cur;
         pos_in.col   = col_cur[2:0];
         pos_in.noise = lfsr_cur[PIX_W-1:0];
         // Galois step: shift right, fold in the taps on a dropped one.
         lfsr_in = (lfsr_cur >> 1) ^ (lfsr_cur[0] ? LFSR_TAPS : '0);
         if (col_next >= eff_width) begin
            col_in = '0;
            row_in = row_cur + 3'd1;
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         lfsr_ff  <= SEED_W'(1);
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         lfsr_ff  <= lfsr_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign pos_valid = valid_ff;
   assign pos       = pos_ff;

endmodule

// ===== hdl/pdt_halftone.sv =====
module pdt_halftone
   import pdt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             pos_valid,
   input  pos_type          pos,
   output logic             take,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] pixel_out
);

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] out_ff, out_in;
   logic [PIX_W-1:0] res;
   logic [1:0]       d0, d1, d2;
   logic [5:0]       w;
   logic [6:0]       odd;
   logic [14:0]      t_ord, p_ord;
   logic [2:0]       odd2;
   logic [12:0]      t2, p8, p24;
   logic             ord_hit;

   // Lowest row and column bits give the high digit, the outer quadrant the low one.
   assign d0 = bayer_cell(pos.row[0], pos.col[0]);
   assign d1 = bayer_cell(pos.row[1], pos.col[1]);
   assign d2 = bayer_cell(pos.row[2], pos.col[2]);

   always_comb begin
      case (cfg.mode)
         MODE_BAYER2: begin
            w     = {4'd0, d0};
            p_ord = {4'd0, pos.pixel, 3'd0};
         end
         MODE_BAYER4: begin
            w     = {2'd0, d0, d1};
            p_ord = {2'd0, pos.pixel, 5'd0};
         end
         default: begin
            w     = {d0, d1, d2};
            p_ord = {pos.pixel, 7'd0};
         end
      endcase
      // (2w+1)*255 as a shift and subtract
      odd     = {w, 1'b1};
      t_ord   = {odd, 8'd0} - {8'd0, odd};
      ord_hit = p_ord > t_ord;

      odd2 = {d0, 1'b1};
      t2   = {2'd0, odd2, 8'd0} - {10'd0, odd2};
      p8   = {2'd0, pos.pixel, 3'd0};
      p24  = {1'b0, pos.pixel, 4'd0} + {2'd0, pos.pixel, 3'd0};
   end

   always_comb begin
      case (cfg.mode)
         MODE_RANDOM: res = (pos.pixel <= pos.noise) ? LEVEL_0 : LEVEL_3;
         MODE_BAYER2,
         MODE_BAYER4,
         MODE_BAYER8: res = ord_hit ? LEVEL_3 : LEVEL_0;
         MODE_LEVEL4: begin
            if (p8 > t2) begin
               res = LEVEL_3;
            end else if (p24 > {t2[11:0], 1'b0}) begin
               res = LEVEL_2;
            end else if (p24 > t2) begin
               res = LEVEL_1;
            end else begin
               res = LEVEL_0;
            end
         end
         default:     res = (pos.pixel <= cfg.fixed_threshold) ? LEVEL_0 : LEVEL_3;
      endcase
   end

   assign take = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (take) begin
         valid_in = pos_valid;
         out_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign pixel_out  = out_ff;

endmodule
